// ===== rtl/core/lbts_pkg.sv =====
// ----------------------------------------------------------------------------
// lbts_pkg
// Shared types, codes and constants of the listen-before-talk tx scheduler.
// ----------------------------------------------------------------------------
package lbts_pkg;

  localparam int QUEUE_DEPTH_DEF     = 16;
  localparam int SAMPLE_SHIFT_DEF    = 3;
  localparam int FULL_SCALE_BITS_DEF = 12;

  localparam int ID_W      = 11;
  localparam int DATA_W    = 8;
  localparam int ENTRY_W   = ID_W + DATA_W;
  localparam int TICK_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int PCT_W     = 7;
  localparam int MODE_W    = 3;
  localparam int PHASE_W   = 2;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RX     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUEUE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TXDONE = 3'd4;

  localparam logic [PHASE_W-1:0] PH_LISTEN = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SEND   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MSG_ID = 3'd4;

  localparam logic [TICK_W-1:0] LISTEN_TICKS_RST  = 16'd1000;
  localparam logic [TICK_W-1:0] WAIT_TICKS_RST    = 16'd500;
  localparam logic [TICK_W-1:0] SEND_TICKS_RST    = 16'd1000;
  localparam logic [TICK_W-1:0] RESUME_TICKS_RST  = 16'd1000;
  localparam logic [ID_W-1:0]   SENSOR_MSG_ID_RST = 11'd256;
  localparam logic [TICK_W-1:0] COUNTDOWN_RST     = 16'd1000;

  localparam int PCT_MAX   = 100;
  localparam int PCT_ROUND = 2;
  localparam int PCT_STEP  = 5;
  localparam int STEP_TBL_N = 128;

  typedef struct packed {
    logic [PHASE_W-1:0] fsm_state;
    logic               send_valid;
    logic [ID_W-1:0]    send_id;
    logic [DATA_W-1:0]  send_data;
    logic               abort_send;
    logic               push_dropped;
    logic [COUNT_W-1:0] queue_count;
    logic [PCT_W-1:0]   sample_percent;
  } result_t;

  typedef logic [STEP_TBL_N-1:0][PCT_W-1:0] step_tbl_t;

  // percentage rounded to the nearest step and clamped
  function automatic step_tbl_t build_step_tbl();
    step_tbl_t tbl;
    int        r;
    int        base;
    r    = PCT_ROUND;
    base = 0;
    for (int i = 0; i < STEP_TBL_N; i++) begin
      tbl[i] = PCT_W'((base > PCT_MAX) ? PCT_MAX : base);
      r = r + 1;
      if (r == PCT_STEP) begin
        r    = 0;
        base = base + PCT_STEP;
      end
    end
    return tbl;
  endfunction

  localparam step_tbl_t STEP_TBL = build_step_tbl();

endpackage

// ===== rtl/core/lbts_ram.sv =====
// ----------------------------------------------------------------------------
// lbts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lbts_quant.sv =====
// ----------------------------------------------------------------------------
// lbts_quant
// Scales a raw converter word to a percentage snapped to steps of five.
// ----------------------------------------------------------------------------
module lbts_quant
  import lbts_pkg::*;
#(
  parameter int SAMPLE_SHIFT    = SAMPLE_SHIFT_DEF,
  parameter int FULL_SCALE_BITS = FULL_SCALE_BITS_DEF
) (
  input  logic [SAMPLE_W-1:0] sample_value,
  output logic [PCT_W-1:0]    percent
);

  localparam int PROD_W = SAMPLE_W + PCT_W;

  logic [SAMPLE_W-1:0] raw;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   pct;

  assign raw  = sample_value >> SAMPLE_SHIFT;
  assign prod = PROD_W'(raw) * PROD_W'(PCT_MAX);
  assign pct  = prod >> FULL_SCALE_BITS;

  always_comb begin
    if (pct >= PROD_W'(STEP_TBL_N)) begin
      percent = PCT_W'(PCT_MAX);
    end else begin
      percent = STEP_TBL[pct[PCT_W-1:0]];
    end
  end

endmodule

// ===== rtl/core/lbts_outbuf.sv =====
// ----------------------------------------------------------------------------
// lbts_outbuf
// Result register with a skid stage so an item is taken while one waits.
// ----------------------------------------------------------------------------
module lbts_outbuf
  import lbts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    load_out;
  logic    accept;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign load_out = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= in_data;
      end
    end else if (accept) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== rtl/core/listen_before_talk_tx_scheduler.sv =====
// ----------------------------------------------------------------------------
// listen_before_talk_tx_scheduler
// Listen/send/wait bus transmit scheduler with message queue and quantizer.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while in_stall is low; its result goes to
// the output register, or to the skid stage while the output is stalled, and
// the timer, state and pointers update on accept. Queue entries live in a RAM
// whose registered read port is always pointed at the next head slot, with a
// one-entry bypass for a write to that slot, so the head is ready when a send
// needs it. The queue holds QUEUE_DEPTH-1 messages; it needs no clearing pass
// after reset. A skid stage behind the result register keeps the input open
// for one more item while a result is stalled. Configuration writes are taken
// in any cycle (cfg_ready is always high) and should be made while idle.
// ----------------------------------------------------------------------------
module listen_before_talk_tx_scheduler
  import lbts_pkg::*;
#(
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
  parameter int SAMPLE_SHIFT    = SAMPLE_SHIFT_DEF,
  parameter int FULL_SCALE_BITS = FULL_SCALE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    mode,
  input  logic [ID_W-1:0]      msg_id,
  input  logic [DATA_W-1:0]    msg_data,
  input  logic [SAMPLE_W-1:0]  sample_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PHASE_W-1:0]   fsm_state,
  output logic                 send_valid,
  output logic [ID_W-1:0]      send_id,
  output logic [DATA_W-1:0]    send_data,
  output logic                 abort_send,
  output logic                 push_dropped,
  output logic [COUNT_W-1:0]   queue_count,
  output logic [PCT_W-1:0]     sample_percent,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [TICK_W-1:0] listen_ticks;
  logic [TICK_W-1:0] wait_ticks;
  logic [TICK_W-1:0] send_ticks;
  logic [TICK_W-1:0] resume_ticks;
  logic [ID_W-1:0]   sensor_msg_id;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [TICK_W-1:0]  countdown, countdown_next;
  logic               tx_busy, tx_busy_next;
  logic [PW-1:0]      write_ptr, write_ptr_next;
  logic [PW-1:0]      read_ptr, read_ptr_next;
  logic               bypass;
  logic [ENTRY_W-1:0] bypass_data;

  logic               accept;
  logic               item_stall;
  logic [PCT_W-1:0]   percent;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] head_stored;
  logic [ENTRY_W-1:0] head;
  logic [ENTRY_W-1:0] push_word;
  logic               push_req;
  logic               push_ok;
  logic [PW-1:0]      wp_inc;
  logic [PW-1:0]      rp_inc;
  logic [TICK_W-1:0]  cnt_ev;
  logic               busy_ev;
  logic               rx;
  logic               expired;
  logic [PW:0]        fill;
  result_t            res;
  result_t            res_q;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !item_stall;
  assign in_stall  = item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_ticks  <= LISTEN_TICKS_RST;
      wait_ticks    <= WAIT_TICKS_RST;
      send_ticks    <= SEND_TICKS_RST;
      resume_ticks  <= RESUME_TICKS_RST;
      sensor_msg_id <= SENSOR_MSG_ID_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LISTEN_TICKS:  listen_ticks  <= cfg_data;
        REG_WAIT_TICKS:    wait_ticks    <= cfg_data;
        REG_SEND_TICKS:    send_ticks    <= cfg_data;
        REG_RESUME_TICKS:  resume_ticks  <= cfg_data;
        REG_SENSOR_MSG_ID: sensor_msg_id <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  lbts_quant #(
    .SAMPLE_SHIFT    (SAMPLE_SHIFT),
    .FULL_SCALE_BITS (FULL_SCALE_BITS)
  ) u_quant (
    .sample_value (sample_value),
    .percent      (percent)
  );

  lbts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (push_ok),
    .waddr (write_ptr),
    .wdata (push_word),
    .raddr (read_ptr_next),
    .rdata (ram_rdata)
  );

  assign head_stored = bypass ? bypass_data : ram_rdata;

  always_comb begin
    push_req  = accept && (mode == MODE_QUEUE || mode == MODE_SAMPLE);
    push_word = (mode == MODE_SAMPLE) ? {sensor_msg_id, 1'b0, percent}
                                      : {msg_id, msg_data};
    wp_inc    = next_slot(write_ptr);
    rp_inc    = next_slot(read_ptr);
    push_ok   = push_req && (wp_inc != read_ptr);
    head      = (write_ptr == read_ptr) ? push_word : head_stored;

    cnt_ev = countdown;
    if (mode == MODE_TICK && countdown != '0) begin
      cnt_ev = countdown - 1'b1;
    end
    busy_ev = (mode == MODE_TXDONE) ? 1'b0 : tx_busy;
    rx      = (mode == MODE_RX);
    expired = (cnt_ev == '0);

    write_ptr_next = push_ok ? wp_inc : write_ptr;
    read_ptr_next  = read_ptr;
    phase_next     = phase;
    countdown_next = cnt_ev;
    tx_busy_next   = busy_ev;

    res                = '0;
    res.push_dropped   = push_req && !push_ok;
    res.sample_percent = (mode == MODE_SAMPLE) ? percent : '0;

    unique case (phase)
      PH_LISTEN: begin
        if (rx) begin
          phase_next     = PH_WAIT;
          countdown_next = wait_ticks;
        end else if (expired) begin
          phase_next     = PH_SEND;
          countdown_next = send_ticks;
        end
      end
      PH_SEND: begin
        if (busy_ev) begin
          res.abort_send = 1'b1;
          tx_busy_next   = 1'b0;
        end
        if (rx) begin
          phase_next     = PH_WAIT;
          countdown_next = wait_ticks;
        end else if (write_ptr_next != read_ptr) begin
          read_ptr_next  = rp_inc;
          res.send_valid = 1'b1;
          res.send_id    = head[ENTRY_W-1:DATA_W];
          res.send_data  = head[DATA_W-1:0];
          tx_busy_next   = 1'b1;
          phase_next     = PH_LISTEN;
          countdown_next = listen_ticks;
        end else if (expired) begin
          phase_next     = PH_LISTEN;
          countdown_next = listen_ticks;
        end
      end
      default: begin
        if (rx) begin
          countdown_next = wait_ticks;
        end else if (expired) begin
          phase_next     = PH_SEND;
          countdown_next = resume_ticks;
        end
      end
    endcase

    if (!accept) begin
      write_ptr_next = write_ptr;
      read_ptr_next  = read_ptr;
      phase_next     = phase;
      countdown_next = countdown;
      tx_busy_next   = tx_busy;
    end

    if (write_ptr_next >= read_ptr_next) begin
      fill = {1'b0, write_ptr_next} - {1'b0, read_ptr_next};
    end else begin
      fill = {1'b0, write_ptr_next} + (PW + 1)'(QUEUE_DEPTH) - {1'b0, read_ptr_next};
    end
    res.queue_count = COUNT_W'(fill);
    res.fsm_state   = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LISTEN;
      countdown <= COUNTDOWN_RST;
      tx_busy   <= 1'b0;
      write_ptr <= '0;
      read_ptr  <= '0;
      bypass    <= 1'b0;
    end else begin
      phase     <= phase_next;
      countdown <= countdown_next;
      tx_busy   <= tx_busy_next;
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
      bypass    <= push_ok && (write_ptr == read_ptr_next);
    end
  end

  always_ff @(posedge clk) begin
    bypass_data <= push_word;
  end

  lbts_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (item_stall),
    .in_data   (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_q)
  );

  assign fsm_state      = res_q.fsm_state;
  assign send_valid     = res_q.send_valid;
  assign send_id        = res_q.send_id;
  assign send_data      = res_q.send_data;
  assign abort_send     = res_q.abort_send;
  assign push_dropped   = res_q.push_dropped;
  assign queue_count    = res_q.queue_count;
  assign sample_percent = res_q.sample_percent;

endmodule

// ===== bench/listen_before_talk_tx_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// listen_before_talk_tx_scheduler_tb
// Self-checking bench for the listen/send/wait tx scheduler. Items are driven
// on the valid/stall input channel and every result is compared field by
// field against a cycle-free model of the timer, queue, quantizer and state
// machine kept in the bench. Directed items cover the reset registers, field
// extremes, unused modes, zero-length timers and aborts; a pressure test
// overfills the queue after a long output hold-off is started; random
// traffic then runs under three register settings and three idle patterns.
// ----------------------------------------------------------------------------
module listen_before_talk_tx_scheduler_tb
  import lbts_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    mode = '0;
  logic [ID_W-1:0]      msg_id = '0;
  logic [DATA_W-1:0]    msg_data = '0;
  logic [SAMPLE_W-1:0]  sample_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PHASE_W-1:0]   fsm_state;
  logic                 send_valid;
  logic [ID_W-1:0]      send_id;
  logic [DATA_W-1:0]    send_data;
  logic                 abort_send;
  logic                 push_dropped;
  logic [COUNT_W-1:0]   queue_count;
  logic [PCT_W-1:0]     sample_percent;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  listen_before_talk_tx_scheduler uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .msg_id         (msg_id),
    .msg_data       (msg_data),
    .sample_value   (sample_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .fsm_state      (fsm_state),
    .send_valid     (send_valid),
    .send_id        (send_id),
    .send_data      (send_data),
    .abort_send     (abort_send),
    .push_dropped   (push_dropped),
    .queue_count    (queue_count),
    .sample_percent (sample_percent),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler model state
  logic [TICK_W-1:0]  listen_len = LISTEN_TICKS_RST;
  logic [TICK_W-1:0]  wait_len = WAIT_TICKS_RST;
  logic [TICK_W-1:0]  send_len = SEND_TICKS_RST;
  logic [TICK_W-1:0]  resume_len = RESUME_TICKS_RST;
  logic [ID_W-1:0]    sensor_id = SENSOR_MSG_ID_RST;
  logic [PHASE_W-1:0] bus_phase = PH_LISTEN;
  logic [TICK_W-1:0]  countdown = COUNTDOWN_RST;
  logic               tx_busy = 1'b0;
  logic [ENTRY_W-1:0] msg_store [QUEUE_DEPTH_DEF];
  logic [COUNT_W-1:0] wr_ptr = '0;
  logic [COUNT_W-1:0] rd_ptr = '0;

  result_t expected_results [$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_token = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      idle_cycles = 0;

  function automatic bit push_message(input logic [ENTRY_W-1:0] entry);
    if (COUNT_W'(wr_ptr + 1'b1) == rd_ptr) return 1'b0;
    msg_store[wr_ptr] = entry;
    wr_ptr = wr_ptr + 1'b1;
    return 1'b1;
  endfunction

  task automatic schedule_step(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                               input logic [DATA_W-1:0] data,
                               input logic [SAMPLE_W-1:0] smp, output result_t r);
    logic               rx;
    logic               expired;
    logic [12:0]        raw;
    logic [19:0]        scaled;
    int                 pct;
    int                 snapped;
    logic [ENTRY_W-1:0] head;
    r  = '0;
    rx = 1'b0;
    case (m)
      MODE_TICK:   if (countdown != '0) countdown = countdown - 1'b1;
      MODE_RX:     rx = 1'b1;
      MODE_QUEUE:  r.push_dropped = !push_message({id, data});
      MODE_SAMPLE: begin
        raw     = 13'(smp >> SAMPLE_SHIFT_DEF);
        scaled  = 20'(raw) * 20'd100;
        pct     = int'(scaled >> FULL_SCALE_BITS_DEF);
        snapped = ((pct + 2) / 5) * 5;
        if (snapped > 100) snapped = 100;
        r.sample_percent = PCT_W'(snapped);
        r.push_dropped = !push_message({sensor_id, 1'b0, PCT_W'(snapped)});
      end
      MODE_TXDONE: tx_busy = 1'b0;
      default: ;
    endcase
    expired = (countdown == '0);
    case (bus_phase)
      PH_LISTEN: begin
        if (rx) begin
          bus_phase = PH_WAIT;
          countdown = wait_len;
        end else if (expired) begin
          bus_phase = PH_SEND;
          countdown = send_len;
        end
      end
      PH_SEND: begin
        if (tx_busy) begin
          r.abort_send = 1'b1;
          tx_busy = 1'b0;
        end
        if (rx) begin
          bus_phase = PH_WAIT;
          countdown = wait_len;
        end else if (wr_ptr != rd_ptr) begin
          head = msg_store[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          r.send_valid = 1'b1;
          r.send_id = head[ENTRY_W-1:DATA_W];
          r.send_data = head[DATA_W-1:0];
          tx_busy = 1'b1;
          bus_phase = PH_LISTEN;
          countdown = listen_len;
        end else if (expired) begin
          bus_phase = PH_LISTEN;
          countdown = listen_len;
        end
      end
      default: begin
        if (rx) begin
          countdown = wait_len;
        end else if (expired) begin
          bus_phase = PH_SEND;
          countdown = resume_len;
        end
      end
    endcase
    r.fsm_state = bus_phase;
    r.queue_count = wr_ptr - rd_ptr;
  endtask

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                           input logic [DATA_W-1:0] data, input logic [SAMPLE_W-1:0] smp);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    mode         = m;
    msg_id       = id;
    msg_data     = data;
    sample_value = smp;
    do @(posedge clk); while (in_stall);
    schedule_step(m, id, data, smp, r);
    expected_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(input logic [TICK_W-1:0] lt, input logic [TICK_W-1:0] wt,
                              input logic [TICK_W-1:0] st, input logic [TICK_W-1:0] rt,
                              input logic [ID_W-1:0] sid);
    logic [TICK_W-1:0]    vals [5];
    logic [CFG_IDX_W-1:0] idx [5];
    vals = '{lt, wt, st, rt, TICK_W'(sid)};
    idx  = '{REG_LISTEN_TICKS, REG_WAIT_TICKS, REG_SEND_TICKS, REG_RESUME_TICKS,
             REG_SENSOR_MSG_ID};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_valid = 1'b1;
      cfg_index = idx[i];
      cfg_data  = vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_LISTEN_TICKS:  listen_len = vals[i];
        REG_WAIT_TICKS:    wait_len = vals[i];
        REG_SEND_TICKS:    send_len = vals[i];
        REG_RESUME_TICKS:  resume_len = vals[i];
        REG_SENSOR_MSG_ID: sensor_id = vals[i][ID_W-1:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_item();
    int                  r;
    logic [MODE_W-1:0]   m;
    logic [SAMPLE_W-1:0] s;
    r = $urandom_range(99);
    if (r < 40) m = MODE_TICK;
    else if (r < 48) m = MODE_RX;
    else if (r < 66) m = MODE_QUEUE;
    else if (r < 80) m = MODE_SAMPLE;
    else if (r < 96) m = MODE_TXDONE;
    else m = MODE_W'($urandom_range(5, 7));
    r = $urandom_range(9);
    if (r == 0) s = '0;
    else if (r == 1) s = '1;
    else s = SAMPLE_W'($urandom);
    send_item(m, ID_W'($urandom), DATA_W'($urandom), s);
  endtask

  // reset register values, field extremes and unused modes
  task automatic test_reset_defaults();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(MODE_SAMPLE, '0, '0, 16'h0000);
    send_item(MODE_SAMPLE, '0, '0, 16'h7ff8);
    send_item(MODE_SAMPLE, '1, '1, 16'hffff);
    send_item(MODE_SAMPLE, '0, '0, 16'h03d8);
    send_item(MODE_QUEUE, 11'h7ff, 8'hff, '0);
    send_item(MODE_QUEUE, 11'h000, 8'h00, '1);
    send_item(3'd5, '1, '1, '1);
    send_item(3'd6, '0, '0, '0);
    send_item(MODE_RX, '0, '0, '0);
    send_item(MODE_TXDONE, '0, '0, '0);
    send_item(3'd7, '0, '0, '0);
  endtask

  // zero and one tick timers, abort of a busy send, rx in the send and wait phases
  task automatic test_timer_paths();
    write_config(16'd0, 16'd1, 16'd1, 16'd1, 11'h7ff);
    send_item(MODE_RX, '0, '0, '0);
    send_item(MODE_TICK, '0, '0, '0);
    send_item(3'd5, '0, '0, '0);
    send_item(3'd6, '0, '0, '0);
    send_item(3'd7, '0, '0, '0);
    send_item(MODE_TXDONE, '0, '0, '0);
    send_item(MODE_RX, '0, '0, '0);
    send_item(MODE_TICK, '0, '0, '0);
    send_item(MODE_SAMPLE, '0, '0, 16'hffff);
    send_item(MODE_TICK, '0, '0, '0);
    send_item(MODE_RX, '0, '0, '0);
    send_item(MODE_TICK, '0, '0, '0);
  endtask

  // overfill the queue after starting a long output hold-off
  task automatic test_queue_pressure();
    write_config(16'd3, 16'd2, 16'd4, 16'd2, 11'h155);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_token++;
    for (int i = 0; i < 40; i++) begin
      if (i % 9 == 8) send_item(MODE_TICK, '0, '0, '0);
      else if (i % 4 == 3) send_item(MODE_SAMPLE, '0, '0, SAMPLE_W'($urandom));
      else send_item(MODE_QUEUE, ID_W'($urandom), DATA_W'($urandom), '0);
    end
    wait_idle();
    for (int i = 0; i < 20; i++) send_random_item();
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_stall_pct = rcv_pct;
    repeat (n) send_random_item();
  endtask

  // output side: random stall plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        want = expected_results.pop_front();
        check_field("fsm_state", int'(fsm_state), int'(want.fsm_state));
        check_field("send_valid", int'(send_valid), int'(want.send_valid));
        check_field("send_id", int'(send_id), int'(want.send_id));
        check_field("send_data", int'(send_data), int'(want.send_data));
        check_field("abort_send", int'(abort_send), int'(want.abort_send));
        check_field("push_dropped", int'(push_dropped), int'(want.push_dropped));
        check_field("queue_count", int'(queue_count), int'(want.queue_count));
        check_field("sample_percent", int'(sample_percent), int'(want.sample_percent));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (in_valid || cfg_valid || expected_results.size() != 0) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_timer_paths();
    test_queue_pressure();
    write_config(16'd1, 16'd1, 16'd1, 16'd1, 11'h000);
    test_random_traffic(260, 25, 82);
    write_config(TICK_W'($urandom_range(1, 12)), TICK_W'($urandom_range(1, 12)),
                 TICK_W'($urandom_range(1, 12)), TICK_W'($urandom_range(1, 12)),
                 ID_W'($urandom));
    test_random_traffic(260, 82, 25);
    write_config(16'hffff, 16'd3, 16'hffff, 16'd2, 11'h7ff);
    test_random_traffic(260, 0, 0);
    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
